// File: hw/rtl/stable_priority_queue_unit_macros.svh
// Assertion macros for the stable priority queue unit.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("spq check failed");
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("spq check failed");
`else
`define SPQ_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// File: hw/rtl/spq_pkg.sv
// Package for the stable priority queue unit: sizes, codes, cell control
// struct and the priority function. Depends on nothing else.
package spq_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned IdW      = 16;
  localparam int unsigned PrioW    = 12;
  localparam int unsigned CntW     = $clog2(Capacity + 1);

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CLASS_OTHER = 2'd0,
    CLASS_AGILE = 2'd1,
    CLASS_TANK  = 2'd2,
    CLASS_MISC  = 2'd3
  } class_e;

  // Broadcast to every cell of the chain in the cycle of a transaction.
  typedef struct packed {
    logic             enq;
    logic             deq;
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
  } spq_ctrl_t;

  // Priority in tenths: x1.5, x0.8 or x1.0 become x15, x8 and x10.
  function automatic logic [PrioW-1:0] prio_tenths(input logic       alive,
                                                   input logic [7:0] agility,
                                                   input logic [1:0] kind);
    logic [PrioW-1:0] a;
    logic [PrioW-1:0] p;
    a = PrioW'(agility);
    unique case (kind)
      CLASS_AGILE: p = (a << 4) - a;
      CLASS_TANK:  p = a << 3;
      default:     p = (a << 3) + (a << 1);
    endcase
    return alive ? p : '0;
  endfunction

endpackage

// File: hw/rtl/spq_cell.sv
// One slot of the sorted chain: holds an id and a priority and moves them
// to or from its neighbours. Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
  input  logic             clk_i,
  input  spq_ctrl_t        ctrl_i,
  input  logic             valid_i,
  input  logic             left_keep_i,
  input  logic [IdW-1:0]   left_id_i,
  input  logic [PrioW-1:0] left_prio_i,
  input  logic [IdW-1:0]   right_id_i,
  input  logic [PrioW-1:0] right_prio_i,
  output logic             keep_o,
  output logic [IdW-1:0]   id_o,
  output logic [PrioW-1:0] prio_o
);

  logic [IdW-1:0]   id_q, id_d;
  logic [PrioW-1:0] prio_q, prio_d;

  // An entry of equal priority stays ahead of the newcomer.
  assign keep_o = valid_i && (prio_q >= ctrl_i.prio);

  always_comb begin
    id_d   = id_q;
    prio_d = prio_q;
    if (ctrl_i.enq) begin
      if (!keep_o) begin
        if (left_keep_i) begin
          id_d   = ctrl_i.id;
          prio_d = ctrl_i.prio;
        end else begin
          id_d   = left_id_i;
          prio_d = left_prio_i;
        end
      end
    end else if (ctrl_i.deq) begin
      id_d   = right_id_i;
      prio_d = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    prio_q <= prio_d;
  end

  assign id_o   = id_q;
  assign prio_o = prio_q;

endmodule

// File: hw/rtl/stable_priority_queue_unit.sv
// Top level of the stable priority queue unit: command decode, fill count,
// result register and the chain of slot cells. Depends on spq_pkg, spq_cell
// and the assertion macro header.
//
// Usage: a transaction is taken at a rising edge where start_i is high and
// busy_o is low. busy_o never rises, so one command may be issued in every
// cycle. command_i selects enqueue, dequeue of the front entry or a plain
// query; code three behaves as a query. For an enqueue the priority in
// tenths is formed from alive_i, agility_i and class_kind_i.
// Every accepted transaction gives exactly one result in the next cycle: done_o
// is high for that single cycle and status_o, front_id_o, front_priority_o,
// queue_size_o and is_empty_o describe the queue after the command. The
// receiver cannot stall, so the result must be taken in that cycle.
// Throughput is one transaction per cycle: every cell of the chain compares
// its priority with the incoming one in parallel and shifts in the same clock
// edge, so the compare in each cell sets the pace.
// Reset clears the fill count, status and result strobe; slot contents are left
// as they are, since only slots below the fill count are ever read.
// An enqueue on a full queue reports status full, a dequeue on an empty
// queue reports status empty, and neither changes the contents.
`include "stable_priority_queue_unit_macros.svh"

module stable_priority_queue_unit import spq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] entry_id_i,
  input  logic        alive_i,
  input  logic [7:0]  agility_i,
  input  logic [1:0]  class_kind_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] front_id_o,
  output logic [11:0] front_priority_o,
  output logic [4:0]  queue_size_o,
  output logic        is_empty_o
);

  logic            accept;
  logic [CntW-1:0] count_q, count_d;
  logic            done_q;
  status_e         status_q, status_d;
  spq_ctrl_t       ctrl;

  logic             keep   [Capacity];
  logic [IdW-1:0]   cell_id   [Capacity];
  logic [PrioW-1:0] cell_prio [Capacity];

  // The chain updates in the same edge that takes a command, so the unit is never busy.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Decode the command and work out the new fill count and status.
  always_comb begin
    ctrl.enq  = 1'b0;
    ctrl.deq  = 1'b0;
    ctrl.id   = IdW'(entry_id_i);
    ctrl.prio = prio_tenths(alive_i, agility_i, class_kind_i);
    status_d  = ST_OK;
    count_d   = count_q;
    if (accept) begin
      unique case (command_i)
        CMD_ENQ: begin
          if (count_q == CntW'(Capacity)) begin
            status_d = ST_FULL;
          end else begin
            ctrl.enq = 1'b1;
            count_d  = count_q + CntW'(1);
          end
        end
        CMD_DEQ: begin
          if (count_q == '0) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.deq = 1'b1;
            count_d  = count_q - CntW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The chain: cell zero is the front. A cell takes the new entry when its
  // left neighbour keeps its place and it does not; it takes its left
  // neighbour's entry when both move. A dequeue shifts every cell one place
  // towards the front.
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic             left_keep;
    logic [IdW-1:0]   left_id, right_id;
    logic [PrioW-1:0] left_prio, right_prio;

    if (i == 0) begin : g_head
      assign left_keep = 1'b1;
      assign left_id   = ctrl.id;
      assign left_prio = ctrl.prio;
    end else begin : g_body
      assign left_keep = keep[i-1];
      assign left_id   = cell_id[i-1];
      assign left_prio = cell_prio[i-1];
    end

    if (i == Capacity - 1) begin : g_tail
      assign right_id   = cell_id[i];
      assign right_prio = cell_prio[i];
    end else begin : g_inner
      assign right_id   = cell_id[i+1];
      assign right_prio = cell_prio[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (count_q > CntW'(i)),
      .left_keep_i  (left_keep),
      .left_id_i    (left_id),
      .left_prio_i  (left_prio),
      .right_id_i   (right_id),
      .right_prio_i (right_prio),
      .keep_o       (keep[i]),
      .id_o         (cell_id[i]),
      .prio_o       (cell_prio[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      count_q  <= count_d;
      done_q   <= accept;
      status_q <= status_d;
    end
  end

  // The result reflects the queue after the last transaction; the front
  // fields read as zero when nothing is held.
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign is_empty_o       = (count_q == '0);
  assign front_id_o       = is_empty_o ? '0 : 16'(cell_id[0]);
  assign front_priority_o = is_empty_o ? '0 : 12'(cell_prio[0]);
  assign queue_size_o     = 5'(count_q);

  `SPQ_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(Capacity))
  `SPQ_ASSERT_NEXT(a_done_follows, clk_i, rst_ni, accept, done_o)
  `SPQ_ASSERT_NEXT(a_enq_grows, clk_i, rst_ni, ctrl.enq, count_q == $past(count_q) + CntW'(1))
  `SPQ_ASSERT_NEXT(a_rejected_holds, clk_i, rst_ni, status_d != ST_OK, $stable(count_q))

endmodule

// File: tb/sv/tb_stable_priority_queue_unit.sv
// Self-checking testbench for the stable priority queue unit: directed and random command
// traffic, with every result compared against a behavioural copy of the sorted queue.
// Depends on spq_pkg and the stable_priority_queue_unit RTL.
module tb_stable_priority_queue_unit import spq_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // Command code three is not named in the package; the block treats it as a query.
  localparam logic [1:0] CmdSpare = 2'd3;

  // One result as the block should report it.
  typedef struct packed {
    status_e          status;
    logic [IdW-1:0]   front_id;
    logic [PrioW-1:0] front_prio;
    logic [CntW-1:0]  size;
    logic             empty;
  } queue_view_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  command_i = CMD_QUERY;
  logic [15:0] entry_id_i = '0;
  logic        alive_i = 1'b0;
  logic [7:0]  agility_i = '0;
  logic [1:0]  class_kind_i = CLASS_OTHER;
  logic        done_o;
  logic [1:0]  status_o;
  logic [15:0] front_id_o;
  logic [11:0] front_priority_o;
  logic [4:0]  queue_size_o;
  logic        is_empty_o;

  stable_priority_queue_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .command_i       (command_i),
    .entry_id_i      (entry_id_i),
    .alive_i         (alive_i),
    .agility_i       (agility_i),
    .class_kind_i    (class_kind_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .front_id_o      (front_id_o),
    .front_priority_o(front_priority_o),
    .queue_size_o    (queue_size_o),
    .is_empty_o      (is_empty_o)
  );

  always #2 clk_i = ~clk_i;

  // The testbench's own copy of the queue: slots sorted by descending priority, with
  // entries of equal priority kept in arrival order.
  logic [IdW-1:0]   sorted_ids   [Capacity];
  logic [PrioW-1:0] sorted_prios [Capacity];
  int unsigned      held_entries = 0;

  // Results predicted for accepted transactions, oldest first.
  queue_view_t      predicted_views [$];
  int unsigned      mismatch_count = 0;

  // Priority in tenths of a unit. The fractional scale factors become exact integer
  // multiples: 1.5 is fifteen tenths and 0.8 is eight tenths.
  function automatic logic [PrioW-1:0] priority_tenths(input logic       alive,
                                                       input logic [7:0] agility,
                                                       input logic [1:0] kind);
    int unsigned base;
    base = agility;
    if (!alive) return '0;
    case (kind)
      CLASS_AGILE: return PrioW'(base * 15);
      CLASS_TANK:  return PrioW'(base * 8);
      default:     return PrioW'(base * 10);
    endcase
  endfunction

  // Applies one accepted transaction to the queue copy and records the result that the
  // block should return for it.
  task automatic predict_transaction(input logic [1:0]  cmd,
                                     input logic [15:0] id,
                                     input logic        alive,
                                     input logic [7:0]  agility,
                                     input logic [1:0]  kind);
    queue_view_t      view;
    logic [PrioW-1:0] prio;
    int unsigned      pos;
    view.status = ST_OK;
    if (cmd == CMD_ENQ) begin
      if (held_entries >= Capacity) begin
        view.status = ST_FULL;
      end else begin
        prio = priority_tenths(alive, agility, kind);
        // The new entry goes behind every entry of greater or equal priority.
        pos = 0;
        while (pos < held_entries && sorted_prios[pos] >= prio) pos++;
        for (int i = held_entries; i > pos; i--) begin
          sorted_ids[i]   = sorted_ids[i-1];
          sorted_prios[i] = sorted_prios[i-1];
        end
        sorted_ids[pos]   = id;
        sorted_prios[pos] = prio;
        held_entries++;
      end
    end else if (cmd == CMD_DEQ) begin
      if (held_entries == 0) begin
        view.status = ST_EMPTY;
      end else begin
        for (int i = 0; i + 1 < held_entries; i++) begin
          sorted_ids[i]   = sorted_ids[i+1];
          sorted_prios[i] = sorted_prios[i+1];
        end
        held_entries--;
      end
    end
    // A query, or the spare code, leaves the queue alone.
    view.size  = CntW'(held_entries);
    view.empty = (held_entries == 0);
    view.front_id   = view.empty ? '0 : sorted_ids[0];
    view.front_prio = view.empty ? '0 : sorted_prios[0];
    predicted_views.push_back(view);
  endtask

  // Drives one transaction and waits for the edge that takes it. It is called just after
  // a rising edge and returns just after the accepting edge, with start_i still high, so
  // the next call can follow without a bubble.
  task automatic send_command(input logic [1:0]  cmd,
                              input logic [15:0] id,
                              input logic        alive,
                              input logic [7:0]  agility,
                              input logic [1:0]  kind);
    start_i      <= 1'b1;
    command_i    <= cmd;
    entry_id_i   <= id;
    alive_i      <= alive;
    agility_i    <= agility;
    class_kind_i <= kind;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predict_transaction(cmd, id, alive, agility, kind);
  endtask

  task automatic idle_cycles(input int unsigned cycles);
    if (cycles == 0) return;
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Commands on an empty queue: a query, a dequeue that must be refused and the spare
  // code, which must behave as a query.
  task automatic test_empty_queue();
    send_command(CMD_QUERY, 16'h1234, 1'b1, 8'd77, CLASS_AGILE);
    send_command(CMD_DEQ, 16'hFFFF, 1'b1, 8'hFF, CLASS_MISC);
    send_command(CmdSpare, 16'hA5A5, 1'b0, 8'h00, CLASS_TANK);
  endtask

  // Each class at agility 255, agile 0, tank 1, a dead entry at 255 and the widest ids.
  task automatic test_priority_classes();
    send_command(CMD_ENQ, 16'hFFFF, 1'b1, 8'd255, CLASS_AGILE);
    send_command(CMD_ENQ, 16'h0001, 1'b1, 8'd255, CLASS_TANK);
    send_command(CMD_ENQ, 16'h0002, 1'b1, 8'd255, CLASS_OTHER);
    send_command(CMD_ENQ, 16'h0003, 1'b1, 8'd255, CLASS_MISC);
    send_command(CMD_ENQ, 16'h0004, 1'b0, 8'd255, CLASS_AGILE);
    send_command(CMD_ENQ, 16'h0000, 1'b1, 8'd0, CLASS_AGILE);
    send_command(CMD_ENQ, 16'h0005, 1'b1, 8'd1, CLASS_TANK);
  endtask

  // Ties: an agile entry of agility 170 matches plain 255 exactly, and a dead entry
  // matches the zero-agility one; both must queue behind their earlier equals.
  task automatic test_stable_order();
    send_command(CMD_ENQ, 16'h00AA, 1'b1, 8'd170, CLASS_AGILE);
    send_command(CMD_ENQ, 16'h00DD, 1'b0, 8'd9, CLASS_OTHER);
  endtask

  // Fill to capacity, try one more enqueue, query, then take a couple from the front.
  task automatic test_full_queue();
    while (held_entries < Capacity) begin
      send_command(CMD_ENQ, 16'($urandom), 1'b1, 8'($urandom_range(0, 255)),
                   2'($urandom_range(0, 3)));
    end
    send_command(CMD_ENQ, 16'hBEEF, 1'b1, 8'd255, CLASS_AGILE);
    send_command(CMD_QUERY, 16'h0000, 1'b0, 8'd0, CLASS_OTHER);
    send_command(CMD_DEQ, 16'h0000, 1'b0, 8'd0, CLASS_OTHER);
    send_command(CMD_DEQ, 16'h0000, 1'b0, 8'd0, CLASS_OTHER);
  endtask

  // One random transaction. The weights set how likely an enqueue or a dequeue is, so a
  // phase can push the queue towards full or towards empty. Agility is often drawn from
  // a short list so that equal priorities, and therefore the ordering rule, come up often.
  task automatic send_random_command(input int unsigned enq_weight,
                                     input int unsigned deq_weight);
    int unsigned pick;
    logic [1:0]  cmd;
    logic [7:0]  agility;
    pick = $urandom_range(0, 99);
    if (pick < enq_weight) cmd = CMD_ENQ;
    else if (pick < enq_weight + deq_weight) cmd = CMD_DEQ;
    else cmd = ($urandom_range(0, 3) == 0) ? CmdSpare : CMD_QUERY;
    case ($urandom_range(0, 3))
      0: agility = 8'd0;
      1: agility = ($urandom_range(0, 1) != 0) ? 8'd170 : 8'd255;
      default: agility = 8'($urandom_range(0, 255));
    endcase
    send_command(cmd, 16'($urandom), ($urandom_range(0, 7) != 0), agility,
                 2'($urandom_range(0, 3)));
  endtask

  // Random traffic in bursts. Each burst has a random length and is followed by a random
  // gap; with gaps off the phase runs back to back, one transaction per cycle.
  task automatic run_random_phase(input int unsigned items,
                                  input int unsigned enq_weight,
                                  input int unsigned deq_weight,
                                  input bit          with_gaps);
    int unsigned burst_left;
    burst_left = $urandom_range(1, 24);
    repeat (items) begin
      if (burst_left == 0) begin
        if (with_gaps) idle_cycles($urandom_range(0, 6));
        burst_left = $urandom_range(1, 24);
      end
      send_random_command(enq_weight, deq_weight);
      burst_left--;
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(200, 45, 40, 1'b1);
    run_random_phase(150, 80, 15, 1'b1);
    run_random_phase(150, 15, 80, 1'b1);
    run_random_phase(200, 45, 45, 1'b0);
  endtask

  task automatic check_field(input string       label,
                             input logic [31:0] expected,
                             input logic [31:0] actual);
    if (actual !== expected) begin
      $display("%0t: %s expected %0d actual %0d", $time, label, expected, actual);
      mismatch_count++;
    end
  endtask

  // Result checker. Outputs are sampled at the rising edge that ends the strobe cycle,
  // before the block updates them, so no check depends on the order within the step.
  always @(posedge clk_i) begin
    queue_view_t view;
    if (rst_ni && done_o === 1'b1) begin
      if (predicted_views.size() == 0) begin
        $display("%0t: result with no pending transaction, expected none actual status %0d",
                 $time, status_o);
        mismatch_count++;
      end else begin
        view = predicted_views.pop_front();
        check_field("status", 32'(view.status), 32'(status_o));
        check_field("front_id", 32'(view.front_id), 32'(front_id_o));
        check_field("front_priority", 32'(view.front_prio), 32'(front_priority_o));
        check_field("queue_size", 32'(view.size), 32'(queue_size_o));
        check_field("is_empty", 32'(view.empty), 32'(is_empty_o));
      end
    end
  end

  // Main sequence: reset once, run the tests in turn, then wait for the last results.
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_queue();
    test_priority_classes();
    test_stable_order();
    test_full_queue();
    test_random_traffic();
    start_i <= 1'b0;
    while (predicted_views.size() != 0) @(posedge clk_i);
    // The extra wait catches any stray strobe.
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: the full run needs well under 20 us even with every gap at its longest.
  initial begin
    #200us;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
